// ===== rtl/core/mmt3_pkg.sv =====
// Package for the 3x3 mirror tiling block: codes, counter widths, defaults.
// Used by matrix_mirror_tiling_3x3_top; depends on nothing else.
package mmt3_pkg;

	localparam int DEF_MAX_ROWS    = 32;
	localparam int DEF_MAX_COLUMNS = 32;
	localparam int DEF_WORD_BITS   = 64;

	localparam int CFG_W        = 6;   // width of both size registers
	localparam int CFG_INDEX_W  = 2;
	localparam int OUT_WORD_W   = 64;
	localparam int OUT_POS_W    = 7;
	localparam int EMIT_CNT_W   = 8;   // holds 3*63-1

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_ROW_COUNT    = 2'd0,
		REG_COLUMN_COUNT = 2'd1
	} cfg_reg_t;

	typedef enum logic {
		FUNC_LOAD = 1'b0,
		FUNC_PULL = 1'b1
	} func_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_MALFORMED = 2'd1,
		ST_NONE      = 2'd2
	} status_t;

	// tile index along one axis: 0 first mirror, 1 original, 2 second mirror
	localparam logic [1:0] TILE_FIRST = 2'd0;
	localparam logic [1:0] TILE_MID   = 2'd1;
	localparam logic [1:0] TILE_LAST  = 2'd2;

endpackage

// ===== rtl/core/matrix_mirror_tiling_3x3_top.sv =====
// Mirror tiling of a loaded matrix into a 3x3 arrangement of flipped copies.
// Depends on mmt3_pkg; the element store is a one-port-write, one-port-read RAM.
//
// A pull result appears in the output register the cycle after its transfer.
// Throughput: one item per cycle; loads always pass, a pull waits only while the
// held result is stalled (the output register is the single read-data register).
// Reset clears counters, flags, size registers and output valid; the store is not cleared.
module matrix_mirror_tiling_3x3_top
	import mmt3_pkg::*;
#(
	parameter int MAX_ROWS    = DEF_MAX_ROWS,
	parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
	parameter int WORD_BITS   = DEF_WORD_BITS
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// configuration write port
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]       cfg_data,
	// input channel
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic                   func,
	input  logic [OUT_WORD_W-1:0]  value,
	input  logic                   row_end,
	// output channel
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [OUT_WORD_W-1:0]  element,
	output logic [OUT_POS_W-1:0]   out_row,
	output logic [OUT_POS_W-1:0]   out_column,
	output logic                   last_in_row,
	output logic                   last,
	output logic [1:0]             status
);

	localparam int DEPTH  = MAX_ROWS * MAX_COLUMNS;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	// size registers and their effective values clipped to the store geometry
	logic [CFG_W-1:0] row_count_q, column_count_q;
	logic [CFG_W-1:0] eff_r, eff_c;

	// load side
	logic [CFG_W-1:0] load_row_q, load_column_q;
	logic             malformed_q;

	// emit side: flat position plus tile index and offset inside the tile
	logic [EMIT_CNT_W-1:0] emit_row_q, emit_column_q;
	logic [1:0]            tile_row_q, tile_col_q;
	logic [CFG_W-1:0]      off_row_q, off_col_q;
	logic                  emit_done_q;

	// output register
	logic                 out_valid_q;
	logic [WORD_BITS-1:0] rdata_q;
	logic                 ok_q;
	logic [OUT_POS_W-1:0] out_row_q, out_column_q;
	logic                 last_in_row_q, last_q;
	status_t              status_q;

	// element store
	logic [WORD_BITS-1:0] mem [DEPTH];

	logic          load_xfer, pull_xfer, empty, load_live, store_we;
	logic          row_end_match;
	logic [ADDR_W-1:0] waddr, raddr;
	logic [CFG_W-1:0]  src_row, src_col;
	logic          lir, lst;
	status_t       pull_status;

	assign eff_r = ({3'b0, row_count_q} > 9'(MAX_ROWS)) ? CFG_W'(MAX_ROWS) : row_count_q;
	assign eff_c = ({3'b0, column_count_q} > 9'(MAX_COLUMNS))
		? CFG_W'(MAX_COLUMNS) : column_count_q;
	assign empty = (eff_r == '0) || (eff_c == '0);

	// hold pulls while the previous result is still stalled; loads pass
	assign in_stall  = out_valid_q && out_stall && (func == FUNC_PULL);
	assign load_xfer = in_valid && !in_stall && (func == FUNC_LOAD);
	assign pull_xfer = in_valid && !in_stall && (func == FUNC_PULL);

	// load addressing
	assign load_live     = !empty && (load_row_q < eff_r);
	assign store_we      = load_xfer && load_live && (load_column_q < eff_c);
	assign row_end_match = (row_end == (load_column_q == (eff_c - CFG_W'(1))));
	assign waddr = ADDR_W'(32'(load_row_q) * MAX_COLUMNS + 32'(load_column_q));

	// mirror: the middle tile keeps the source order, the outer tiles reverse it
	assign src_row = (tile_row_q == TILE_MID) ? off_row_q : eff_r - CFG_W'(1) - off_row_q;
	assign src_col = (tile_col_q == TILE_MID) ? off_col_q : eff_c - CFG_W'(1) - off_col_q;
	assign raddr   = ADDR_W'(32'(src_row) * MAX_COLUMNS + 32'(src_col));

	assign lir = (tile_col_q == TILE_LAST) && (off_col_q == eff_c - CFG_W'(1));
	assign lst = lir && (tile_row_q == TILE_LAST) && (off_row_q == eff_r - CFG_W'(1));

	always_comb begin
		if (empty || emit_done_q) begin
			pull_status = ST_NONE;
		end else if (malformed_q) begin
			pull_status = ST_MALFORMED;
		end else begin
			pull_status = ST_OK;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q    <= '0;
			column_count_q <= '0;
			load_row_q     <= '0;
			load_column_q  <= '0;
			malformed_q    <= 1'b0;
			emit_row_q     <= '0;
			emit_column_q  <= '0;
			tile_row_q     <= TILE_FIRST;
			tile_col_q     <= TILE_FIRST;
			off_row_q      <= '0;
			off_col_q      <= '0;
			emit_done_q    <= 1'b0;
			out_valid_q    <= 1'b0;
		end else begin
			if (pull_xfer) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end

			if (cfg_we) begin
				// a size write restarts loading and emission; stored words stay
				case (cfg_index)
					REG_ROW_COUNT: begin
						row_count_q <= cfg_data;
					end
					REG_COLUMN_COUNT: begin
						column_count_q <= cfg_data;
					end
					default: begin
					end
				endcase
				if (cfg_index == REG_ROW_COUNT || cfg_index == REG_COLUMN_COUNT) begin
					load_row_q    <= '0;
					load_column_q <= '0;
					malformed_q   <= 1'b0;
					emit_row_q    <= '0;
					emit_column_q <= '0;
					tile_row_q    <= TILE_FIRST;
					tile_col_q    <= TILE_FIRST;
					off_row_q     <= '0;
					off_col_q     <= '0;
					emit_done_q   <= 1'b0;
				end
			end else if (load_xfer && load_live) begin
				if (!row_end_match) begin
					malformed_q <= 1'b1;
				end
				if (row_end) begin
					load_row_q    <= load_row_q + CFG_W'(1);
					load_column_q <= '0;
				end else if (load_column_q != '1) begin
					load_column_q <= load_column_q + CFG_W'(1);
				end
			end else if (pull_xfer && pull_status == ST_OK) begin
				if (lir) begin
					emit_column_q <= '0;
					tile_col_q    <= TILE_FIRST;
					off_col_q     <= '0;
					if (lst) begin
						emit_done_q <= 1'b1;
					end else begin
						emit_row_q <= emit_row_q + EMIT_CNT_W'(1);
						if (off_row_q == eff_r - CFG_W'(1)) begin
							off_row_q  <= '0;
							tile_row_q <= tile_row_q + 2'd1;
						end else begin
							off_row_q <= off_row_q + CFG_W'(1);
						end
					end
				end else begin
					emit_column_q <= emit_column_q + EMIT_CNT_W'(1);
					if (off_col_q == eff_c - CFG_W'(1)) begin
						off_col_q  <= '0;
						tile_col_q <= tile_col_q + 2'd1;
					end else begin
						off_col_q <= off_col_q + CFG_W'(1);
					end
				end
			end
		end
	end

	// store write and registered read; result fields load with the read
	always_ff @(posedge clk) begin
		if (store_we) begin
			mem[waddr] <= value[WORD_BITS-1:0];
		end
		if (pull_xfer) begin
			rdata_q  <= mem[raddr];
			status_q <= pull_status;
			ok_q     <= (pull_status == ST_OK);
			if (pull_status == ST_OK) begin
				out_row_q     <= emit_row_q[OUT_POS_W-1:0];
				out_column_q  <= emit_column_q[OUT_POS_W-1:0];
				last_in_row_q <= lir;
				last_q        <= lst;
			end else begin
				out_row_q     <= '0;
				out_column_q  <= '0;
				last_in_row_q <= 1'b0;
				last_q        <= 1'b0;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign element     = ok_q ? OUT_WORD_W'(rdata_q) : '0;
	assign out_row     = out_row_q;
	assign out_column  = out_column_q;
	assign last_in_row = last_in_row_q;
	assign last        = last_q;
	assign status      = status_q;

`ifndef SYNTH
	a_tile_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		tile_row_q != 2'd3 && tile_col_q != 2'd3)
		else $error("tile index out of range");

	a_off_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		(eff_r != '0) |-> (off_row_q < eff_r))
		else $error("row offset beyond tile height");

	a_load_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		load_row_q <= eff_r)
		else $error("load row beyond configured rows");

	a_last_implies_row_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && last_q |-> last_in_row_q && ok_q)
		else $error("final flag without row end");

	a_pull_fills_output: assert property (@(posedge clk) disable iff (!arst_n)
		pull_xfer |=> out_valid_q)
		else $error("pull transfer left no result");
`endif

endmodule
